// ===== rtl/clr_pkg.sv =====
// Shared types and codes for the compacting list.
`timescale 1ns / 1ps

package clr_pkg;

	// Request action codes
	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_ERASE  = 2'd1,
		ACT_READ   = 2'd2,
		ACT_CLEAR  = 2'd3
	} clr_action_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic append;   // write value into the cell at target
		logic erase;    // cells at or above target take their upper neighbor
		logic rd_start; // cell at target copies its entry into the read carry
		logic rd_move;  // read carry steps one cell toward cell 0
	} clr_cmd_t;

endpackage

// ===== rtl/clr_req_if.sv =====
// Request channel: action, index and value with valid/ready.
`timescale 1ns / 1ps

interface clr_req_if #(
	parameter int IW = 9,
	parameter int EW = 32
);
	logic          valid;
	logic          ready;
	logic [1:0]    action;
	logic [IW-1:0] index;
	logic [EW-1:0] value;

	modport source (output valid, action, index, value, input ready);
	modport sink   (input valid, action, index, value, output ready);
endinterface

// ===== rtl/clr_rsp_if.sv =====
// Response channel: read data, count, slot and error flag with valid/ready.
`timescale 1ns / 1ps

interface clr_rsp_if #(
	parameter int IW = 9,
	parameter int CW = 10,
	parameter int EW = 32
);
	logic          valid;
	logic          ready;
	logic [EW-1:0] read_data;
	logic [CW-1:0] entry_count;
	logic [IW-1:0] write_slot;
	logic          bad_index;

	modport source (output valid, read_data, entry_count, write_slot, bad_index,
		input ready);
	modport sink   (input valid, read_data, entry_count, write_slot, bad_index,
		output ready);
endinterface

// ===== rtl/compacting_list_ring_overwrite.sv =====
// Top level: compacting ordered list with overwrite when full, built as a cell chain.
`timescale 1ns / 1ps

// Channel  Direction  Moves
// -------  ---------  ----------------------------------------------------
// req      in         one request: action, index, value
// rsp      out        one response per request: read_data, entry_count,
//                     write_slot, bad_index
//
// Append, erase, clear and any bad-index request answer at once; the
// response is registered and shows up the cycle after acceptance.
// A good read sends the entry along the carry chain one cell per cycle
// down to cell 0; the response loads once it lands there.
// arst_n clears count, pointer and control; entries hold no reset.
// A stalled response holds; a new request is taken in the same cycle the
// pending response drains.

module compacting_list_ring_overwrite #(
	parameter int DEPTH       = 512,
	parameter int ENTRY_WIDTH = 32
) (
	input logic  clk,
	input logic  arst_n,
	clr_req_if.sink   req,
	clr_rsp_if.source rsp
);
	import clr_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = ENTRY_WIDTH;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [IW-1:0] hops_q;    // carry steps still to go on a read
	logic          ov_q;
	logic [EW-1:0] rdata_q;
	logic [CW-1:0] cnt_out_q;
	logic [IW-1:0] slot_q;
	logic          bad_q;

	clr_cmd_t      cmd;
	clr_action_t   act;
	logic          take;
	logic          out_free;
	logic          rsp_load;  // response register loads this cycle
	logic          idx_ok;
	logic          full;
	logic [CW-1:0] wrap_ptr;
	logic [IW-1:0] app_slot;
	logic [IW-1:0] target;
	logic [CW-1:0] count_nx;
	logic [CW-1:0] ptr_nx;

	logic [EW-1:0] entry_w [DEPTH];
	logic [EW-1:0] carry_w [DEPTH];

	// Request decode and next count / pointer
	always_comb begin
		act      = clr_action_t'(req.action);
		out_free = !ov_q || rsp.ready;
		idx_ok   = CW'(req.index) < count_q;
		full     = count_q == FULL_CNT;
		// pointer at capacity wraps before use
		wrap_ptr = (ptr_q >= FULL_CNT) ? '0 : ptr_q;
		app_slot = full ? wrap_ptr[IW-1:0] : count_q[IW-1:0];

		req.ready = (state_q == ST_IDLE) && out_free;
		take      = req.valid && req.ready;

		cmd.append   = take && act == ACT_APPEND;
		cmd.erase    = take && act == ACT_ERASE && idx_ok;
		cmd.rd_start = take && act == ACT_READ && idx_ok;
		cmd.rd_move  = (state_q == ST_READ) && hops_q != '0;

		// other requests load at once; a good read loads when the carry lands
		rsp_load = ((state_q == ST_IDLE) && take && !cmd.rd_start) ||
			((state_q == ST_READ) && hops_q == '0 && out_free);

		target = (act == ACT_APPEND) ? app_slot : req.index;

		count_nx = count_q;
		ptr_nx   = ptr_q;
		case (act)
			ACT_APPEND: begin
				if (full) begin
					ptr_nx = wrap_ptr + ONE_CNT;
				end else begin
					count_nx = count_q + ONE_CNT;
					ptr_nx   = count_q + ONE_CNT;
				end
			end
			ACT_ERASE: begin
				if (idx_ok) begin
					count_nx = count_q - ONE_CNT;
					// pointer above the hole follows its entry down
					if (ptr_q > CW'(req.index)) begin
						ptr_nx = ptr_q - ONE_CNT;
					end
				end
			end
			ACT_CLEAR: begin
				count_nx = '0;
				ptr_nx   = '0;
			end
			default: begin
			end
		endcase
	end

	// Cell chain: cell i looks up to cell i+1; the top cell keeps itself
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [EW-1:0] up_entry;
		logic [EW-1:0] up_carry;

		if (i == DEPTH - 1) begin : g_top
			assign up_entry = entry_w[i];
			assign up_carry = '0;
		end else begin : g_mid
			assign up_entry = entry_w[i+1];
			assign up_carry = carry_w[i+1];
		end

		clr_cell #(
			.EW  (EW),
			.IW  (IW),
			.POS (i)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.target   (target),
			.value    (req.value),
			.up_entry (up_entry),
			.up_carry (up_carry),
			.entry    (entry_w[i]),
			.carry    (carry_w[i])
		);
	end

	// Control and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			hops_q    <= '0;
			ov_q      <= 1'b0;
			rdata_q   <= '0;
			cnt_out_q <= '0;
			slot_q    <= '0;
			bad_q     <= 1'b0;
		end else begin
			if (rsp_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						count_q <= count_nx;
						ptr_q   <= ptr_nx;
						if (cmd.rd_start) begin
							// good read: wait for the carry to reach cell 0
							state_q <= ST_READ;
							hops_q  <= req.index;
						end else begin
							rdata_q   <= '0;
							cnt_out_q <= count_nx;
							slot_q    <= (act == ACT_APPEND) ? app_slot : '0;
							bad_q     <= (act == ACT_ERASE || act == ACT_READ) && !idx_ok;
						end
					end
				end
				ST_READ: begin
					if (hops_q != '0) begin
						hops_q <= hops_q - IW'(1);
					end else if (out_free) begin
						rdata_q   <= carry_w[0];
						cnt_out_q <= count_q;
						slot_q    <= '0;
						bad_q     <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.read_data   = rdata_q;
	assign rsp.entry_count = cnt_out_q;
	assign rsp.write_slot  = slot_q;
	assign rsp.bad_index   = bad_q;

endmodule

// ===== rtl/clr_cell.sv =====
// One list cell: holds an entry and one stage of the read carry chain.
`timescale 1ns / 1ps

module clr_cell #(
	parameter int EW  = 32,
	parameter int IW  = 9,
	parameter int POS = 0
) (
	input  logic              clk,
	input  clr_pkg::clr_cmd_t cmd,
	input  logic [IW-1:0]     target,
	input  logic [EW-1:0]     value,
	input  logic [EW-1:0]     up_entry,
	input  logic [EW-1:0]     up_carry,
	output logic [EW-1:0]     entry,
	output logic [EW-1:0]     carry
);
	import clr_pkg::*;

	localparam logic [IW-1:0] MY_POS = IW'(POS);

	logic [EW-1:0] entry_q;
	logic [EW-1:0] carry_q;

	always_ff @(posedge clk) begin
		if (cmd.append && target == MY_POS) begin
			entry_q <= value;
		end else if (cmd.erase && MY_POS >= target) begin
			entry_q <= up_entry;
		end

		if (cmd.rd_start && target == MY_POS) begin
			carry_q <= entry_q;
		end else if (cmd.rd_move) begin
			carry_q <= up_carry;
		end
	end

	assign entry = entry_q;
	assign carry = carry_q;

endmodule
